FILE: design/hpd_pkg.sv
// ----------------------------------------------------------------------------
// hpd_pkg
// Types and fixed constants shared by the heading PID drive controller files.
// ----------------------------------------------------------------------------
package hpd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN   = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd3;
    localparam logic [2:0] REG_TARGET_HDG  = 3'd4;
    localparam logic [2:0] REG_TARGET_SPD  = 3'd5;
    localparam logic [2:0] REG_RAMP_INC    = 3'd6;
    localparam logic [2:0] REG_RUN_LIMIT   = 3'd7;

    // Heading arithmetic in 1/16 degree
    localparam int HALF_TURN = 2880;
    localparam int FULL_TURN = 5760;

    // Command saturation in percent
    localparam int CMD_LIMIT = 100;

    // Integral accumulator limits (40-bit signed)
    localparam logic signed [39:0] INTEG_MAX = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] INTEG_MIN = {1'b1, {39{1'b0}}};

    typedef enum logic [1:0] {
        MODE_DIST     = 2'd0,
        MODE_TIMED    = 2'd1,
        MODE_PIVOT    = 2'd2,
        MODE_ONE_SIDE = 2'd3
    } t_mode;

    typedef struct packed {
        logic               restart;
        logic        [12:0] heading_sample;
        logic signed [23:0] avg_distance;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] left_command;
        logic signed [7:0] right_command;
        logic              done_res;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  cfg_index;
        logic [23:0] cfg_data;
    } t_cfg_item;

endpackage

FILE: design/hpd_chan_if.sv
// ----------------------------------------------------------------------------
// hpd_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface hpd_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/heading_pid_drive_controller.sv
// ----------------------------------------------------------------------------
// heading_pid_drive_controller
// Heading-hold PID drive controller: one control tick in, one pair of
// drive commands and a done flag out.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload                                       Handshake
// i_in     in   restart, heading_sample, avg_distance         valid/ready
// o_out    out  left_command, right_command, done_res         valid/ready
// i_cfg    in   cfg_index, cfg_data (register write)          valid/ready, always ready
//
// Throughput is one item per clock while i_in.ready is high. Each result goes
// through input register, wrap, gain multiply, state update, derivative
// multiply, correction sum and command shaping. The run state (ramp, integral,
// previous error, tick count, finished) closes its loop in the single
// state-update stage, so back-to-back items see each other's updates.
// Reset clears the configuration registers, the run state, the stage valids
// and the result queue. Results wait in a QUEUE_DEPTH-entry queue; i_in.ready
// drops once QUEUE_DEPTH items are accepted but not yet delivered, so a
// stalled consumer never loses a result and the pipeline itself never stalls.
// ----------------------------------------------------------------------------
module heading_pid_drive_controller import hpd_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hpd_chan_if.sink    i_in,
    hpd_chan_if.source  o_out,
    hpd_chan_if.sink    i_cfg
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_mode              r_mode;
    logic signed [23:0] r_prop_gain;
    logic signed [23:0] r_integ_gain;
    logic signed [23:0] r_deriv_gain;
    logic        [12:0] r_target_heading;
    logic signed [7:0]  r_target_speed;
    logic signed [15:0] r_ramp_inc;
    logic        [23:0] r_run_limit;

    logic cfg_write;
    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_DIST;
            r_prop_gain      <= '0;
            r_integ_gain     <= '0;
            r_deriv_gain     <= '0;
            r_target_heading <= '0;
            r_target_speed   <= '0;
            r_ramp_inc       <= '0;
            r_run_limit      <= '0;
        end else if (cfg_write) begin
            case (i_cfg.data.cfg_index)
                REG_MODE:       r_mode           <= t_mode'(i_cfg.data.cfg_data[1:0]);
                REG_PROP_GAIN:  r_prop_gain      <= $signed(i_cfg.data.cfg_data);
                REG_INTEG_GAIN: r_integ_gain     <= $signed(i_cfg.data.cfg_data);
                REG_DERIV_GAIN: r_deriv_gain     <= $signed(i_cfg.data.cfg_data);
                REG_TARGET_HDG: r_target_heading <= i_cfg.data.cfg_data[12:0];
                REG_TARGET_SPD: r_target_speed   <= $signed(i_cfg.data.cfg_data[7:0]);
                REG_RAMP_INC:   r_ramp_inc       <= $signed(i_cfg.data.cfg_data[15:0]);
                REG_RUN_LIMIT:  r_run_limit      <= i_cfg.data.cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Credit count: items accepted but not yet delivered. Bounding it by
    // the queue depth guarantees the queue always has room.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_credit;
    logic             in_take;
    logic             out_take;
    logic             queue_empty;

    assign i_in.ready = (r_credit < CNT_W'(QUEUE_DEPTH));
    assign in_take    = i_in.valid && i_in.ready;
    assign o_out.valid = !queue_empty;
    assign out_take   = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if (in_take && !out_take) begin
            r_credit <= r_credit + CNT_W'(1);
        end else if (!in_take && out_take) begin
            r_credit <= r_credit - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Stage valids
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= in_take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    t_in_item r_s1_item;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item <= i_in.data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: wrap the heading error into +-180 degrees, check distance
    // ------------------------------------------------------------------
    logic signed [13:0] raw_err;
    logic signed [13:0] wrap_err;
    logic        [23:0] dist_mag;
    logic               dist_over;

    always_comb begin
        raw_err  = $signed({1'b0, r_s1_item.heading_sample})
                 - $signed({1'b0, r_target_heading});
        wrap_err = raw_err;
        // Subtract a full turn above a half turn, then add one below minus
        // a half turn; both tests run in order.
        if (wrap_err > $signed(14'(HALF_TURN))) begin
            wrap_err = wrap_err - $signed(14'(FULL_TURN));
        end
        if (wrap_err < -$signed(14'(HALF_TURN))) begin
            wrap_err = wrap_err + $signed(14'(FULL_TURN));
        end
        dist_mag  = r_s1_item.avg_distance[23] ? 24'(-r_s1_item.avg_distance)
                                               : 24'(r_s1_item.avg_distance);
        dist_over = (dist_mag > r_run_limit);
    end

    logic signed [12:0] r_s2_err;
    logic               r_s2_dist_over;
    logic               r_s2_restart;

    always_ff @(posedge i_clk) begin
        r_s2_err       <= wrap_err[12:0];
        r_s2_dist_over <= dist_over;
        r_s2_restart   <= r_s1_item.restart;
    end

    // ------------------------------------------------------------------
    // Stage 3: proportional and integral products
    // ------------------------------------------------------------------
    logic signed [36:0] r_s3_pe;
    logic signed [36:0] r_s3_ie;
    logic signed [12:0] r_s3_err;
    logic               r_s3_dist_over;
    logic               r_s3_restart;

    always_ff @(posedge i_clk) begin
        r_s3_pe        <= 37'(r_prop_gain)  * 37'(r_s2_err);
        r_s3_ie        <= 37'(r_integ_gain) * 37'(r_s2_err);
        r_s3_err       <= r_s2_err;
        r_s3_dist_over <= r_s2_dist_over;
        r_s3_restart   <= r_s2_restart;
    end

    // ------------------------------------------------------------------
    // Stage 4: run state update (the only loop in the block)
    // ------------------------------------------------------------------
    logic signed [16:0] r_ramp;
    logic signed [39:0] r_integ;
    logic signed [8:0]  r_prev_err;
    logic        [23:0] r_tick;
    logic               r_finished;

    logic signed [16:0] n_ramp;
    logic signed [39:0] n_integ;
    logic signed [8:0]  n_prev_err;
    logic        [23:0] n_tick;
    logic               n_finished;

    logic signed [16:0] ramp0;
    logic signed [39:0] integ0;
    logic signed [8:0]  prev0;
    logic        [23:0] tick0;
    logic               fin0;
    logic signed [17:0] ramp_wide;
    logic        [17:0] ramp_mag;
    logic signed [8:0]  spd_wide;
    logic        [8:0]  spd_mag;
    logic        [17:0] ramp_cap;
    logic signed [40:0] integ_sum;
    logic signed [12:0] err_bias;
    logic signed [13:0] diff;

    always_comb begin
        // Restart clears the run before this item is judged.
        ramp0  = r_s3_restart ? '0 : r_ramp;
        integ0 = r_s3_restart ? '0 : r_integ;
        prev0  = r_s3_restart ? '0 : r_prev_err;
        tick0  = r_s3_restart ? '0 : r_tick;
        fin0   = r_s3_restart ? 1'b0 : r_finished;

        if (r_mode == MODE_DIST) begin
            n_finished = fin0 || r_s3_dist_over;
        end else begin
            n_finished = fin0 || (tick0 > r_run_limit);
        end

        ramp_wide = 18'(ramp0);
        ramp_mag  = ramp_wide[17] ? 18'(-ramp_wide) : 18'(ramp_wide);
        spd_wide  = 9'(r_target_speed);
        spd_mag   = spd_wide[8] ? 9'(-spd_wide) : 9'(spd_wide);
        ramp_cap  = {1'b0, spd_mag, 8'b0};

        integ_sum = 41'(integ0) + 41'(r_s3_ie);
        err_bias  = r_s3_err + (r_s3_err[12] ? 13'sd15 : 13'sd0);
        diff      = $signed({r_s3_err[12], r_s3_err}) - $signed({prev0, 4'b0000});

        // Frozen once finished: hold the (possibly cleared) state.
        n_ramp     = ramp0;
        n_integ    = integ0;
        n_prev_err = prev0;
        n_tick     = tick0;

        if (!n_finished) begin
            if (tick0 != '1) begin
                n_tick = tick0 + 24'd1;
            end
            if ((r_mode == MODE_DIST || r_mode == MODE_TIMED) && (ramp_mag < ramp_cap)) begin
                n_ramp = ramp0 + 17'(r_ramp_inc);
            end
            if (integ_sum[40] != integ_sum[39]) begin
                n_integ = integ_sum[40] ? INTEG_MIN : INTEG_MAX;
            end else begin
                n_integ = integ_sum[39:0];
            end
            // Whole degrees, truncated toward zero
            n_prev_err = err_bias[12:4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp     <= '0;
            r_integ    <= '0;
            r_prev_err <= '0;
            r_tick     <= '0;
            r_finished <= 1'b0;
        end else if (r_v3) begin
            r_ramp     <= n_ramp;
            r_integ    <= n_integ;
            r_prev_err <= n_prev_err;
            r_tick     <= n_tick;
            r_finished <= n_finished;
        end
    end

    logic signed [36:0] r_s4_pe;
    logic signed [13:0] r_s4_diff;
    logic signed [39:0] r_s4_integ;
    logic signed [16:0] r_s4_ramp;
    logic               r_s4_done;

    always_ff @(posedge i_clk) begin
        r_s4_pe    <= r_s3_pe;
        r_s4_diff  <= diff;
        r_s4_integ <= n_integ;
        r_s4_ramp  <= n_ramp;
        r_s4_done  <= n_finished;
    end

    // ------------------------------------------------------------------
    // Stage 5: derivative product
    // ------------------------------------------------------------------
    logic signed [37:0] r_s5_de;
    logic signed [36:0] r_s5_pe;
    logic signed [39:0] r_s5_integ;
    logic signed [16:0] r_s5_ramp;
    logic               r_s5_done;

    always_ff @(posedge i_clk) begin
        r_s5_de    <= 38'(r_deriv_gain) * 38'(r_s4_diff);
        r_s5_pe    <= r_s4_pe;
        r_s5_integ <= r_s4_integ;
        r_s5_ramp  <= r_s4_ramp;
        r_s5_done  <= r_s4_done;
    end

    // ------------------------------------------------------------------
    // Stage 6: correction sum and base speed at 2^-20 percent
    // ------------------------------------------------------------------
    logic signed [41:0] r_s6_corr;
    logic signed [28:0] r_s6_base;
    logic               r_s6_done;

    always_ff @(posedge i_clk) begin
        r_s6_corr <= 42'(r_s5_pe) + 42'(r_s5_integ) + 42'(r_s5_de);
        r_s6_base <= {r_s5_ramp, 12'b0};
        r_s6_done <= r_s5_done;
    end

    // ------------------------------------------------------------------
    // Command shaping into the result queue
    // ------------------------------------------------------------------
    function automatic logic signed [7:0] f_to_cmd(input logic signed [43:0] v);
        logic signed [23:0] q;
        q = v[43:20];
        // Shift floors; step up toward zero when a negative value had a fraction.
        if (v[43] && (v[19:0] != '0)) begin
            q = q + 24'sd1;
        end
        if (q > $signed(24'(CMD_LIMIT))) begin
            return 8'(CMD_LIMIT);
        end
        if (q < -$signed(24'(CMD_LIMIT))) begin
            return -8'(CMD_LIMIT);
        end
        return q[7:0];
    endfunction

    logic signed [43:0] base_w;
    logic signed [43:0] corr_w;
    logic signed [43:0] left_v;
    logic signed [43:0] right_v;
    t_out_item          result;

    always_comb begin
        base_w = 44'(r_s6_base);
        corr_w = 44'(r_s6_corr);
        case (r_mode)
            MODE_DIST: begin
                left_v  = base_w - corr_w;
                right_v = base_w + corr_w;
            end
            MODE_TIMED: begin
                left_v  = -base_w - corr_w;
                right_v = -base_w + corr_w;
            end
            MODE_PIVOT: begin
                left_v  = -corr_w;
                right_v = corr_w;
            end
            MODE_ONE_SIDE: begin
                // Only the reversing side drives; clamp to non-positive.
                left_v  = corr_w[43]  ? corr_w  : '0;
                right_v = !corr_w[43] ? -corr_w : '0;
            end
            default: begin
                left_v  = '0;
                right_v = '0;
            end
        endcase

        if (r_s6_done) begin
            result.left_command  = '0;
            result.right_command = '0;
            result.done_res      = 1'b1;
        end else begin
            result.left_command  = f_to_cmd(left_v);
            result.right_command = f_to_cmd(right_v);
            result.done_res      = 1'b0;
        end
    end

    hpd_out_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (r_v6),
        .i_wr_data (result),
        .i_rd_en   (out_take),
        .o_rd_data (o_out.data),
        .o_empty   (queue_empty)
    );

endmodule

FILE: design/hpd_out_fifo.sv
// ----------------------------------------------------------------------------
// hpd_out_fifo
// Small register queue holding finished result items until taken.
// ----------------------------------------------------------------------------
module hpd_out_fifo import hpd_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr_en,
    input  t_out_item i_wr_data,
    input  logic      i_rd_en,
    output t_out_item o_rd_data,
    output logic      o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_out_item          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    function automatic logic [PTR_W-1:0] f_next_ptr(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return ptr + PTR_W'(1);
    endfunction

    always_comb begin
        n_count = r_count;
        if (i_wr_en && !i_rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_wr_en && i_rd_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= f_next_ptr(r_wr_ptr);
            end
            if (i_rd_en) begin
                r_rd_ptr <= f_next_ptr(r_rd_ptr);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_empty   = (r_count == '0);

endmodule

FILE: design/hpd_checker.sv
// ----------------------------------------------------------------------------
// hpd_checker
// Port-level checks for the heading PID drive controller, bound to its top.
// ----------------------------------------------------------------------------
module hpd_checker import hpd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // A finished run drives nothing.
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.done_res |->
            i_out_data.left_command == 8'sd0 && i_out_data.right_command == 8'sd0)
        else $error("done result with nonzero commands");

    // Commands stay inside the saturation band.
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            i_out_data.left_command  <= 8'sd100 && i_out_data.left_command  >= -8'sd100 &&
            i_out_data.right_command <= 8'sd100 && i_out_data.right_command >= -8'sd100)
        else $error("command outside saturation band");

    // Reset empties the queue and frees all credit.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("queue not empty after reset");

endmodule

bind heading_pid_drive_controller hpd_checker u_hpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
